@@ hw/rtl/temporal_join_matcher_assert.svh @@
// Assertion macros for the port-level checker of the join matcher.
`ifndef TEMPORAL_JOIN_MATCHER_ASSERT_SVH
`define TEMPORAL_JOIN_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TJM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("join matcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TJM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("join matcher assertion failed");

`endif

@@ hw/rtl/tjm_pkg.sv @@
// Package with the default table depth, widths, command codes and the table row type of the join matcher.
`timescale 1ns / 1ps

package tjm_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;

	localparam int unsigned CMD_W  = 2;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned WGT_W  = 32;
	localparam int unsigned PIDX_W = 32;
	localparam int unsigned IDX_W  = 6;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]         row_key;
		logic signed [TIME_W-1:0] lower_time;
		logic signed [TIME_W-1:0] upper_time;
		logic                     upper_open;
	} row_t;

	localparam int unsigned ROW_W = $bits(row_t);

endpackage

@@ hw/rtl/tjm_in_if.sv @@
// Input channel carrying load, probe and clear transactions.
`timescale 1ns / 1ps

interface tjm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [tjm_pkg::CMD_W-1:0]             command;
	logic [tjm_pkg::KEY_W-1:0]             match_key;
	logic signed [tjm_pkg::TIME_W-1:0]     time_value;
	logic signed [tjm_pkg::TIME_W-1:0]     upper_time;
	logic                                  upper_open;
	logic signed [tjm_pkg::WGT_W-1:0]      sample_weight;
	logic [tjm_pkg::PIDX_W-1:0]            population_index;

	modport source (output valid, command, match_key, time_value, upper_time, upper_open,
		sample_weight, population_index, input ready);
	modport sink (input valid, command, match_key, time_value, upper_time, upper_open,
		sample_weight, population_index, output ready);
endinterface

@@ hw/rtl/tjm_out_if.sv @@
// Output channel carrying match result transactions.
`timescale 1ns / 1ps

interface tjm_out_if;
	logic                       valid;
	logic                       ready;
	logic                       match_valid;
	logic [tjm_pkg::IDX_W-1:0]  peripheral_index;
	logic [tjm_pkg::PIDX_W-1:0] population_index_out;
	logic                       last;

	modport source (output valid, match_valid, peripheral_index, population_index_out, last,
		input ready);
	modport sink (input valid, match_valid, peripheral_index, population_index_out, last,
		output ready);
endinterface

@@ hw/rtl/temporal_join_matcher.sv @@
// A load or clear completes as it is accepted; a probe holds the input until its scan
// ends, also on an empty table or a weight that is not positive.
// Throughput: one row per cycle unless the sink stalls, set by the single RAM read port.
// A result is registered when the next hit or the end of the scan releases it.
// Reset empties the table (row count zero) and sets use_time_filter to one; the row
// memory itself is not cleared, as rows at or above the count are never read.
`timescale 1ns / 1ps

// Top level of the temporal interval join matcher.
//
// Peripheral rows live in one synchronous RAM, one row per entry, written in load
// order at the current row count. A probe captures its key, timestamp and index,
// then a read pointer walks the RAM from entry zero up to the row count (no entry when
// the weight is not positive). The RAM data arrives in the next cycle in stage s1, where
// the key and time window are compared.
//
// Because the final result of a probe must carry the last flag, a hit is not sent
// out at once. It is parked in a pending register; the next hit pushes it out with
// last low, and the end of the scan sends it with last high. When no hit was parked
// the end of the scan sends a single no-match result instead.
//
// The whole scan advances only when the output register can take a new result, so
// a stalled sink freezes the read pointer, the s1 stage and the RAM read data (the
// read enable is dropped), and no result is lost. Inputs are taken only between
// probes; a load or clear completes in the cycle it is accepted.
module temporal_join_matcher #(
	parameter int unsigned TABLE_DEPTH = tjm_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	tjm_in_if.sink            items,
	tjm_out_if.source         results
);

	// Address and count widths follow the table depth.
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// Control state.
	logic          state_q;
	logic [CW-1:0] row_count_q;
	logic          use_time_filter_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] scan_cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          pend_q;
	logic [AW-1:0] pend_idx_q;
	logic          out_valid_q;

	// Probe context, held for the length of the scan.
	logic [tjm_pkg::KEY_W-1:0]         probe_key_q;
	logic signed [tjm_pkg::TIME_W-1:0] probe_time_q;
	logic [tjm_pkg::PIDX_W-1:0]        probe_pidx_q;

	// Output payload register.
	logic                       out_match_q;
	logic [tjm_pkg::IDX_W-1:0]  out_idx_q;
	logic [tjm_pkg::PIDX_W-1:0] out_pidx_q;
	logic                       out_last_q;

	logic          accept;
	logic          is_load;
	logic          is_probe;
	logic          is_clear;
	logic          weight_positive;
	logic          wr_en;
	tjm_pkg::row_t wr_row;
	tjm_pkg::row_t rd_row;
	logic          go;
	logic          issue;
	logic          key_eq;
	logic          in_window;
	logic          hit_s1;
	logic          scan_done;
	logic          push_pend;
	logic          out_load;

	// Input side: transactions are taken only while no probe is being scanned.
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign is_load     = accept && (items.command == tjm_pkg::CMD_LOAD);
	assign is_probe    = accept && (items.command == tjm_pkg::CMD_PROBE);
	assign is_clear    = accept && (items.command == tjm_pkg::CMD_CLEAR);

	// Only a strictly positive weight lets the probe scan the table.
	assign weight_positive = !items.sample_weight[tjm_pkg::WGT_W-1] &&
		(items.sample_weight != '0);

	// A load into a full table is dropped.
	assign wr_en = is_load && (row_count_q < CW'(TABLE_DEPTH));

	always_comb begin
		wr_row.row_key    = items.match_key;
		wr_row.lower_time = items.time_value;
		wr_row.upper_time = items.upper_time;
		wr_row.upper_open = items.upper_open;
	end

	// The scan moves forward only when the output register is free or is being emptied.
	assign go    = !out_valid_q || results.ready;
	assign issue = (state_q == ST_SCAN) && go && (rd_ptr_q < scan_cnt_q);

	tjm_ram #(
		.WIDTH (tjm_pkg::ROW_W),
		.DEPTH (TABLE_DEPTH)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_count_q[AW-1:0]),
		.wr_data (wr_row),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (rd_row)
	);

	// Stage s1: compare the row read in the previous step against the probe.
	assign key_eq    = (rd_row.row_key == probe_key_q);
	assign in_window = (rd_row.lower_time <= probe_time_q) &&
		(rd_row.upper_open || (rd_row.upper_time > probe_time_q));
	assign hit_s1    = rd_vld_s1 && key_eq && (!use_time_filter_q || in_window);

	// The scan ends once every row has been read and compared.
	assign scan_done = (state_q == ST_SCAN) && go && !rd_vld_s1 && (rd_ptr_q >= scan_cnt_q);
	assign push_pend = (state_q == ST_SCAN) && go && hit_s1 && pend_q;
	assign out_load  = push_pend || scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			row_count_q       <= '0;
			use_time_filter_q <= 1'b1;
			rd_ptr_q          <= '0;
			scan_cnt_q        <= '0;
			rd_vld_s1         <= 1'b0;
			pend_q            <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				use_time_filter_q <= cfg_wr_data;
			end

			if (wr_en) begin
				row_count_q <= row_count_q + CW'(1);
			end else if (is_clear) begin
				row_count_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (is_probe) begin
						state_q    <= ST_SCAN;
						rd_ptr_q   <= '0;
						scan_cnt_q <= weight_positive ? row_count_q : '0;
						rd_vld_s1  <= 1'b0;
						pend_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (go) begin
						rd_vld_s1 <= issue;
						if (issue) begin
							rd_ptr_q <= rd_ptr_q + CW'(1);
						end
						if (hit_s1) begin
							pend_q <= 1'b1;
						end
						if (scan_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (is_probe) begin
			probe_key_q  <= items.match_key;
			probe_time_q <= items.time_value;
			probe_pidx_q <= items.population_index;
		end
		if (issue) begin
			rd_idx_s1 <= rd_ptr_q[AW-1:0];
		end
		if ((state_q == ST_SCAN) && go && hit_s1) begin
			pend_idx_q <= rd_idx_s1;
		end
		if (out_load) begin
			out_pidx_q <= probe_pidx_q;
			out_last_q <= scan_done;
			out_match_q <= scan_done ? pend_q : 1'b1;
			out_idx_q   <= (scan_done && !pend_q) ? '0 : tjm_pkg::IDX_W'(pend_idx_q);
		end
	end

	assign results.valid                = out_valid_q;
	assign results.match_valid          = out_match_q;
	assign results.peripheral_index     = out_idx_q;
	assign results.population_index_out = out_pidx_q;
	assign results.last                 = out_last_q;

endmodule

@@ hw/rtl/tjm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tjm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/tjm_checker.sv @@
// Port-level checker for the join matcher, bound to the top level.
`timescale 1ns / 1ps
`include "temporal_join_matcher_assert.svh"

module tjm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [tjm_pkg::CMD_W-1:0]  in_command,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_match_valid,
	input logic [tjm_pkg::IDX_W-1:0]  out_peripheral_index,
	input logic [tjm_pkg::PIDX_W-1:0] out_population_index,
	input logic                       out_last
);

	// A stalled result keeps its content.
	`TJM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_match_valid) && $stable(out_peripheral_index) && $stable(out_population_index) && $stable(out_last))

	// A no-match result closes its probe and reports row zero.
	`TJM_ASSERT_NOW(a_nomatch_shape, clk, arst_n, out_valid && !out_match_valid, out_last && (out_peripheral_index == '0))

	// An accepted probe blocks further transactions while the table is scanned.
	`TJM_ASSERT_NEXT(a_probe_blocks, clk, arst_n, in_valid && in_ready && (in_command == tjm_pkg::CMD_PROBE), !in_ready)

	// Loads and clears complete at once and leave the input open.
	`TJM_ASSERT_NEXT(a_load_open, clk, arst_n, in_valid && in_ready && (in_command != tjm_pkg::CMD_PROBE), in_ready)

endmodule

bind temporal_join_matcher tjm_checker u_tjm_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (items.valid),
	.in_ready             (items.ready),
	.in_command           (items.command),
	.out_valid            (results.valid),
	.out_ready            (results.ready),
	.out_match_valid      (results.match_valid),
	.out_peripheral_index (results.peripheral_index),
	.out_population_index (results.population_index_out),
	.out_last             (results.last)
);
